// File: sv/pcred_pkg.sv
// Package for the port change room event detector.
// Holds the shared constants and the transaction type that the top level hands to the
// event emitter. No dependencies.
package pcred_pkg;

  // Width of one port sample and of one indicator byte.
  localparam int unsigned BitsPerPort = 8;
  localparam int unsigned IdxW        = 3;
  localparam int unsigned RoomW       = 7;

  // Port field width and the indicator byte value after reset (all indicators dark).
  localparam int unsigned PortW       = 2;
  localparam logic [7:0]  LedResetVal = 8'hFF;

  // Everything the emitter needs to replay the events of one changed sample.
  typedef struct packed {
    logic [BitsPerPort-1:0] mask;      // changed bits still to be reported
    logic [BitsPerPort-1:0] sample;    // the new sample
    logic [RoomW-1:0]       room_base; // room number of bit 0, less one
    logic [BitsPerPort-1:0] led;       // updated indicator byte of the row
  } pcred_load_t;

  // One result transaction.
  typedef struct packed {
    logic [RoomW-1:0]       room;
    logic                   unlocked;
    logic [BitsPerPort-1:0] led_pattern;
    logic                   last;
  } pcred_event_t;

endpackage

// File: sv/pcred_if.sv
// Valid/ready channel interfaces for the port change room event detector.
// Depends on nothing; widths follow the fixed field widths of the samples and events.
interface pcred_in_if;
  logic       valid;
  logic       ready;
  logic       row;
  logic [1:0] port;
  logic [7:0] sample;

  modport source (output valid, output row, output port, output sample, input ready);
  modport sink   (input valid, input row, input port, input sample, output ready);
endinterface

interface pcred_out_if;
  logic       valid;
  logic       ready;
  logic [6:0] room;
  logic       unlocked;
  logic [7:0] led_pattern;
  logic       last;

  modport source (output valid, output room, output unlocked, output led_pattern,
                  output last, input ready);
  modport sink   (input valid, input room, input unlocked, input led_pattern,
                  input last, output ready);
endinterface

// File: sv/port_change_room_event_detector_unit.sv
// Top level of the port change room event detector.
// Depends on pcred_pkg, the channel interfaces in pcred_if.sv and the emitter pcred_emit.
//
// Channel   Direction  Payload                              Handshake
// in_ch_i   sink       row, port, sample                    valid / ready
// out_ch_o  source     room, unlocked, led_pattern, last    valid / ready
//
// A sample is compared with the stored one in the cycle it is accepted; the changed-bit
// mask goes to the emitter register, which sends one event per cycle unless stalled.
// An item therefore yields one event per changed bit (1 to 8), or none if nothing
// changed; the next sample is accepted in the cycle the last event is taken.
// Reset clears all stored samples to zero and all indicator bytes to 0xFF.
// A stalled output holds the current event; input ready then stays low.
module port_change_room_event_detector_unit
  import pcred_pkg::*;
#(
  parameter int unsigned PORTS_PER_ROW = 4,
  parameter int unsigned ROW_COUNT     = 2
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  pcred_in_if.sink    in_ch_i,
  pcred_out_if.source out_ch_o
);

  localparam int unsigned Slots  = ROW_COUNT * PORTS_PER_ROW;
  localparam int unsigned SlotW  = (Slots > 1) ? $clog2(Slots) : 1;
  localparam int unsigned RowW   = (ROW_COUNT > 1) ? $clog2(ROW_COUNT) : 1;
  localparam logic [3:0]  PortLimit = 4'(PORTS_PER_ROW);
  localparam logic [3:0]  RowLimit  = 4'(ROW_COUNT);

  logic [BitsPerPort-1:0] prev_q [Slots];
  logic [BitsPerPort-1:0] led_q  [ROW_COUNT];

  logic                   accept, in_range, changed, free;
  logic [SlotW-1:0]       slot;
  logic [RowW-1:0]        row_idx;
  logic [BitsPerPort-1:0] diff, led_new;
  logic [PortW:0]         led_bit;
  pcred_load_t            load_data;
  pcred_event_t           ev;

  assign in_ch_i.ready = free;
  assign accept        = in_ch_i.valid && free;

  // Slot lookup and range checks for the incoming sample.
  assign in_range = ({3'b000, in_ch_i.row} < RowLimit) &&
                    ({2'b00, in_ch_i.port} < PortLimit);
  assign slot     = SlotW'(int'(in_ch_i.row) * PORTS_PER_ROW + int'(in_ch_i.port));
  assign row_idx  = RowW'(in_ch_i.row);
  assign diff     = in_range ? (prev_q[slot] ^ in_ch_i.sample) : '0;
  assign changed  = (diff != '0);

  // Indicator bit of the port is lit (cleared) while the sample is nonzero.
  assign led_bit = {in_ch_i.port, 1'b1};
  always_comb begin
    led_new = led_q[row_idx];
    led_new[led_bit] = (in_ch_i.sample == '0);
  end

  // Transaction for the emitter; an unchanged or out-of-range sample loads an empty mask.
  assign load_data.mask      = diff;
  assign load_data.sample    = in_ch_i.sample;
  assign load_data.room_base = RoomW'((int'(in_ch_i.row) * PORTS_PER_ROW
                                       + int'(in_ch_i.port)) * BitsPerPort);
  assign load_data.led       = led_new;

  // Stored samples and indicator bytes change only when a sample actually differs.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int s = 0; s < Slots; s++) begin
        prev_q[s] <= '0;
      end
      for (int r = 0; r < ROW_COUNT; r++) begin
        led_q[r] <= LedResetVal;
      end
    end else if (accept && changed) begin
      prev_q[slot]   <= in_ch_i.sample;
      led_q[row_idx] <= led_new;
    end
  end

  pcred_emit u_emit (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .load_i      (accept),
    .load_data_i (load_data),
    .free_o      (free),
    .ev_valid_o  (out_ch_o.valid),
    .ev_ready_i  (out_ch_o.ready),
    .ev_o        (ev)
  );

  // Result transaction onto the output channel.
  assign out_ch_o.room        = ev.room;
  assign out_ch_o.unlocked    = ev.unlocked;
  assign out_ch_o.led_pattern = ev.led_pattern;
  assign out_ch_o.last        = ev.last;

endmodule

// File: sv/pcred_emit.sv
// Event emitter: holds the changed-bit mask of one sample and reports one event per cycle
// while the output is ready, lowest bit first. Depends on pcred_pkg.
module pcred_emit
  import pcred_pkg::*;
(
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         load_i,
  input  pcred_load_t  load_data_i,
  output logic         free_o,
  output logic         ev_valid_o,
  input  logic         ev_ready_i,
  output pcred_event_t ev_o
);

  logic [BitsPerPort-1:0] mask_q, mask_rest;
  logic [BitsPerPort-1:0] sample_q;
  logic [RoomW-1:0]       base_q;
  logic [BitsPerPort-1:0] led_q;
  logic [IdxW-1:0]        idx;
  logic                   single;

  // Lowest pending bit; the loop runs high to low so the lowest set bit wins.
  always_comb begin
    idx = '0;
    for (int b = BitsPerPort - 1; b >= 0; b--) begin
      if (mask_q[b]) begin
        idx = IdxW'(b);
      end
    end
  end

  // Mask with its lowest bit removed, and whether that bit is the last one.
  assign mask_rest = mask_q & (mask_q - BitsPerPort'(1));
  assign single    = (mask_rest == '0);

  assign ev_valid_o         = (mask_q != '0);
  assign ev_o.room          = base_q + RoomW'(idx) + RoomW'(1);
  assign ev_o.unlocked      = sample_q[idx];
  assign ev_o.led_pattern   = led_q;
  assign ev_o.last          = single;

  // A new sample may be taken once the final pending event leaves in this cycle.
  assign free_o = !ev_valid_o || (ev_ready_i && single);

  // Pending mask: loaded on a new transaction, otherwise shrinks per delivered event.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mask_q <= '0;
    end else if (load_i) begin
      mask_q <= load_data_i.mask;
    end else if (ev_valid_o && ev_ready_i) begin
      mask_q <= mask_rest;
    end
  end

  // Payload of the pending sample.
  always_ff @(posedge clk_i) begin
    if (load_i) begin
      sample_q <= load_data_i.sample;
      base_q   <= load_data_i.room_base;
      led_q    <= load_data_i.led;
    end
  end

endmodule
